### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, codes and command tables for the AT command and update
// frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

	// parser mode
	typedef enum logic [1:0] {
		MODE_COMMAND,
		MODE_SKIP,
		MODE_LENGTH,
		MODE_BODY
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_VERSION     = 3'd0,
		ST_UPDATE      = 3'd1,
		ST_OK          = 3'd2,
		ST_CMD_ERROR   = 3'd3,
		ST_BAD_LENGTH  = 3'd4,
		ST_BAD_SUM     = 3'd5,
		ST_BAD_ADDRESS = 3'd6
	} status_t;

	// event kinds handed from parser to verdict unit
	typedef enum logic [2:0] {
		EV_VERSION,
		EV_UPDATE,
		EV_CMD_ERROR,
		EV_BAD_LENGTH,
		EV_FRAME_END
	} event_kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ADDRESS_LOWEST   = 2'd0,
		REG_ADDRESS_HIGHEST  = 2'd1,
		REG_ALIGN_MASK       = 2'd2,
		REG_MAX_FRAME_LENGTH = 2'd3
	} reg_index_t;

	typedef struct packed {
		event_kind_t kind;
		logic        sum_ok;
		logic [15:0] address;
		logic [7:0]  length;
	} event_t;

	typedef struct packed {
		logic [15:0] address_lowest;
		logic [15:0] address_highest;
		logic [15:0] align_mask;
		logic [7:0]  max_frame_length;
	} cfg_t;

	localparam logic [7:0]  LINE_FEED        = 8'h0A;
	localparam logic [7:0]  MIN_FRAME_LENGTH = 8'd5;
	localparam int          VERSION_CMD_LEN  = 4;
	localparam int          UPDATE_CMD_LEN   = 9;
	localparam int          EVQ_DEPTH        = 2;

	localparam logic [15:0] RST_ADDRESS_LOWEST   = 16'h8000;
	localparam logic [15:0] RST_ADDRESS_HIGHEST  = 16'h9A00;
	localparam logic [15:0] RST_ALIGN_MASK       = 16'h000F;
	localparam logic [7:0]  RST_MAX_FRAME_LENGTH = 8'h25;

	// "AT+V"
	function automatic logic [7:0] version_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h41;
			2'd1: c = 8'h54;
			2'd2: c = 8'h2B;
			default: c = 8'h56;
		endcase
		return c;
	endfunction

	// "AT+UPDATE"
	function automatic logic [7:0] update_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h41;
			4'd1: c = 8'h54;
			4'd2: c = 8'h2B;
			4'd3: c = 8'h55;
			4'd4: c = 8'h50;
			4'd5: c = 8'h44;
			4'd6: c = 8'h41;
			4'd7: c = 8'h54;
			4'd8: c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/afc_front.sv
// ----------------------------------------------------------------------------
// afc_front
// Byte parser: matches commands, skips to line feed, walks the update frame
// and posts one event per verdict into the event queue.
// ----------------------------------------------------------------------------
module afc_front #(
	parameter int COMMAND_BUFFER_BYTES = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic [7:0]      rx_byte,
	input  afc_pkg::cfg_t   cfg,
	output logic            ev_push,
	output afc_pkg::event_t ev
);
	import afc_pkg::*;

	localparam int CNT_W = $clog2(COMMAND_BUFFER_BYTES + 1);

	mode_t             mode_q, mode_d;
	mode_t             after_q, after_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [1:0]        flags_q, flags_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        len_q, len_d;
	logic [7:0]        idx_q, idx_d;
	logic [15:0]       addr_q, addr_d;

	logic [CNT_W:0]    cmd_next;
	logic [1:0]        flags_new;
	logic              hit_version;
	logic              hit_update;
	logic              cmd_full;
	logic              len_bad;
	logic [7:0]        sum_new;
	logic [15:0]       addr_new;
	logic              body_last;

	// command compare against both tables
	assign cmd_next     = {1'b0, count_q} + (CNT_W+1)'(1);
	assign flags_new[0] = flags_q[0] && (count_q < CNT_W'(VERSION_CMD_LEN))
		&& (version_char(count_q[1:0]) == rx_byte);
	assign flags_new[1] = flags_q[1] && (count_q < CNT_W'(UPDATE_CMD_LEN))
		&& (update_char(4'(count_q)) == rx_byte);
	assign hit_version  = flags_new[0] && (cmd_next == (CNT_W+1)'(VERSION_CMD_LEN));
	assign hit_update   = flags_new[1] && (cmd_next == (CNT_W+1)'(UPDATE_CMD_LEN));
	assign cmd_full     = cmd_next >= (CNT_W+1)'(COMMAND_BUFFER_BYTES);

	// length byte bounds
	assign len_bad = (rx_byte < MIN_FRAME_LENGTH) || (rx_byte > cfg.max_frame_length);

	// frame body sum, address capture, end of frame
	assign sum_new = sum_q + rx_byte;
	always_comb begin
		addr_new = addr_q;
		if (idx_q == 8'd2) begin
			addr_new[15:8] = rx_byte;
		end else if (idx_q == 8'd3) begin
			addr_new[7:0] = rx_byte;
		end
	end
	assign body_last = !(({1'b0, idx_q} + 9'd1) < {1'b0, len_q});

	// next state
	always_comb begin
		mode_d  = mode_q;
		after_d = after_q;
		count_d = count_q;
		flags_d = flags_q;
		sum_d   = sum_q;
		len_d   = len_q;
		idx_d   = idx_q;
		addr_d  = addr_q;
		if (byte_valid) begin
			unique case (mode_q)
				MODE_COMMAND: begin
					if (hit_version || hit_update || cmd_full) begin
						count_d = '0;
						flags_d = 2'b11;
						mode_d  = MODE_SKIP;
						after_d = (!hit_version && hit_update) ? MODE_LENGTH : MODE_COMMAND;
					end else begin
						count_d = cmd_next[CNT_W-1:0];
						flags_d = flags_new;
					end
				end
				MODE_SKIP: begin
					if (rx_byte == LINE_FEED) begin
						mode_d  = after_q;
						after_d = MODE_COMMAND;
					end
				end
				MODE_LENGTH: begin
					if (len_bad) begin
						mode_d  = MODE_SKIP;
						after_d = MODE_COMMAND;
					end else begin
						len_d  = rx_byte;
						sum_d  = rx_byte;
						idx_d  = 8'd1;
						addr_d = '0;
						mode_d = MODE_BODY;
					end
				end
				MODE_BODY: begin
					sum_d  = sum_new;
					addr_d = addr_new;
					if (body_last) begin
						idx_d   = '0;
						mode_d  = MODE_SKIP;
						after_d = MODE_COMMAND;
					end else begin
						idx_d = idx_q + 8'd1;
					end
				end
				default: begin
					mode_d = MODE_COMMAND;
				end
			endcase
		end
	end

	// event outputs
	always_comb begin
		ev_push    = 1'b0;
		ev.kind    = EV_FRAME_END;
		ev.sum_ok  = (sum_new == 8'd0);
		ev.address = addr_new;
		ev.length  = len_q;
		if (byte_valid) begin
			unique case (mode_q)
				MODE_COMMAND: begin
					if (hit_version) begin
						ev_push = 1'b1;
						ev.kind = EV_VERSION;
					end else if (hit_update) begin
						ev_push = 1'b1;
						ev.kind = EV_UPDATE;
					end else if (cmd_full) begin
						ev_push = 1'b1;
						ev.kind = EV_CMD_ERROR;
					end
				end
				MODE_LENGTH: begin
					if (len_bad) begin
						ev_push = 1'b1;
						ev.kind = EV_BAD_LENGTH;
					end
				end
				MODE_BODY: begin
					ev_push = body_last;
				end
				default: begin
					ev_push = 1'b0;
				end
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_COMMAND;
			after_q <= MODE_COMMAND;
			count_q <= '0;
			flags_q <= 2'b11;
			sum_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			addr_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			after_q <= after_d;
			count_q <= count_d;
			flags_q <= flags_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			addr_q  <= addr_d;
		end
	end

	// frame walk stays inside a legal frame
	a_body_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_BODY |->
			(len_q >= MIN_FRAME_LENGTH) && (idx_q < len_q) && (idx_q != 8'd0))
		else $error("frame index out of range");

	// skip only ever resumes into command or length mode
	a_after_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(after_q == MODE_COMMAND) || (after_q == MODE_LENGTH))
		else $error("bad resume mode");

	// command buffer never holds a full buffer's worth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(COMMAND_BUFFER_BYTES))
		else $error("command count overflow");

	// update start always leads into the skip that precedes the length byte
	a_update_skip: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push && ev.kind == EV_UPDATE |=> mode_q == MODE_SKIP && after_q == MODE_LENGTH)
		else $error("update start not followed by skip to length");

endmodule

### rtl/afc_queue.sv
// ----------------------------------------------------------------------------
// afc_queue
// Short event queue between the parser and the verdict unit.
// ----------------------------------------------------------------------------
module afc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  afc_pkg::event_t wr_data,
	output logic            q_full,
	input  logic            rd,
	output logic            q_valid,
	output afc_pkg::event_t rd_data
);
	import afc_pkg::*;

	localparam int PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

	event_t           entry_q [EVQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = count_q == CNT_W'(EVQ_DEPTH);
	assign q_valid = count_q != '0;
	assign rd_data = entry_q[rd_ptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/afc_back.sv
// ----------------------------------------------------------------------------
// afc_back
// Verdict unit: turns parser events into result transactions, checks frame
// address range and alignment, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module afc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ev_valid,
	input  afc_pkg::event_t ev,
	output logic            ev_pop,
	input  afc_pkg::cfg_t   cfg,
	output logic            empty,
	input  logic            pop,
	output logic [2:0]      status,
	output logic [15:0]     frame_address,
	output logic [7:0]      payload_bytes
);
	import afc_pkg::*;

	logic        res_valid_q;
	status_t     status_q, status_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  payload_q, payload_d;
	logic        addr_bad;

	assign ev_pop = ev_valid && (!res_valid_q || pop);

	// address range and alignment
	assign addr_bad = (ev.address < cfg.address_lowest)
		|| (ev.address > cfg.address_highest)
		|| ((ev.address & cfg.align_mask) != 16'd0);

	// event decode
	always_comb begin
		addr_d    = '0;
		payload_d = '0;
		unique case (ev.kind)
			EV_VERSION:    status_d = ST_VERSION;
			EV_UPDATE:     status_d = ST_UPDATE;
			EV_CMD_ERROR:  status_d = ST_CMD_ERROR;
			EV_BAD_LENGTH: status_d = ST_BAD_LENGTH;
			EV_FRAME_END: begin
				if (!ev.sum_ok) begin
					status_d = ST_BAD_SUM;
				end else if (addr_bad) begin
					status_d = ST_BAD_ADDRESS;
					addr_d   = ev.address;
				end else begin
					status_d  = ST_OK;
					addr_d    = ev.address;
					payload_d = ev.length - MIN_FRAME_LENGTH;
				end
			end
			default: status_d = ST_CMD_ERROR;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ev_pop) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ev_pop) begin
			status_q  <= status_d;
			addr_q    <= addr_d;
			payload_q <= payload_d;
		end
	end

	assign empty         = !res_valid_q;
	assign status        = status_q;
	assign frame_address = addr_q;
	assign payload_bytes = payload_q;

endmodule

### rtl/at_command_and_update_frame_checker.sv
// ----------------------------------------------------------------------------
// at_command_and_update_frame_checker
// AT command recognizer and update frame checker, one UART byte per
// transaction, zero or one result transaction per byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while results are popped as they appear.
// Path: each result is written from the parser into the event queue, then
// taken into the verdict result register, which drives the ports.
// The two-entry event queue sets how far the parser runs ahead of a stalled
// consumer before full rises.
// Reset: asynchronous; parser returns to command mode, queue and result
// register empty, configuration registers take their default limits.
module at_command_and_update_frame_checker #(
	parameter int COMMAND_BUFFER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [15:0] frame_address,
	output logic [7:0]  payload_bytes,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import afc_pkg::*;

	cfg_t   cfg_q;
	logic   byte_valid;
	logic   ev_push;
	event_t ev_in;
	logic   q_valid;
	event_t ev_out;
	logic   ev_pop;

	assign byte_valid = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_lowest   <= RST_ADDRESS_LOWEST;
			cfg_q.address_highest  <= RST_ADDRESS_HIGHEST;
			cfg_q.align_mask       <= RST_ALIGN_MASK;
			cfg_q.max_frame_length <= RST_MAX_FRAME_LENGTH;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_ADDRESS_LOWEST:   cfg_q.address_lowest   <= cfg_data;
				REG_ADDRESS_HIGHEST:  cfg_q.address_highest  <= cfg_data;
				REG_ALIGN_MASK:       cfg_q.align_mask       <= cfg_data;
				REG_MAX_FRAME_LENGTH: cfg_q.max_frame_length <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// byte parser
	afc_front #(
		.COMMAND_BUFFER_BYTES(COMMAND_BUFFER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.cfg        (cfg_q),
		.ev_push    (ev_push),
		.ev         (ev_in)
	);

	// event queue
	afc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ev_push),
		.wr_data (ev_in),
		.q_full  (full),
		.rd      (ev_pop),
		.q_valid (q_valid),
		.rd_data (ev_out)
	);

	// verdict and result register
	afc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_valid      (q_valid),
		.ev            (ev_out),
		.ev_pop        (ev_pop),
		.cfg           (cfg_q),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.frame_address (frame_address),
		.payload_bytes (payload_bytes)
	);

endmodule

### dv/afc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_result_checker
// Follows the byte, result and register channels of the AT command and
// update frame checker. It keeps its own model of the parser and the limits,
// predicts the verdict of every accepted byte and compares each popped result
// field by field against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module afc_result_checker #(
	parameter int CMD_BUF_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  status,
	input  logic [15:0] frame_address,
	input  logic [7:0]  payload_bytes,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending_count,
	output int          checked_count
);
	import afc_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam logic [8*VERSION_CMD_LEN-1:0] VERSION_TEXT = "AT+V";
	localparam logic [8*UPDATE_CMD_LEN-1:0]  UPDATE_TEXT  = "AT+UPDATE";

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
		logic [7:0]  payload;
	} verdict_t;

	// parser copy
	mode_t       cur_mode;
	mode_t       resume_mode;
	int          cmd_len;
	bit          could_be_version;
	bit          could_be_update;
	logic [7:0]  sum_acc;
	logic [7:0]  frame_len;
	int          frame_pos;
	logic [15:0] frame_addr;

	// limit registers copy
	logic [15:0] lim_low;
	logic [15:0] lim_high;
	logic [15:0] lim_mask;
	logic [7:0]  lim_max_len;

	verdict_t    pending_verdicts[$];

	task automatic record(input status_t st, input logic [15:0] a, input logic [7:0] p);
		verdict_t v;
		v.status = st;
		v.addr = a;
		v.payload = p;
		pending_verdicts.push_back(v);
	endtask

	task automatic leave_command(input mode_t next);
		cmd_len = 0;
		could_be_version = 1'b1;
		could_be_update = 1'b1;
		cur_mode = MODE_SKIP;
		resume_mode = next;
	endtask

	// one received byte through the parser, verdict queued if it ends something
	task automatic parse_rx_byte(input logic [7:0] b);
		int next_len;
		case (cur_mode)
			MODE_COMMAND: begin
				next_len = cmd_len + 1;
				if (could_be_version && (cmd_len >= VERSION_CMD_LEN ||
						VERSION_TEXT[8*(VERSION_CMD_LEN-1-cmd_len) +: 8] != b))
					could_be_version = 1'b0;
				if (could_be_update && (cmd_len >= UPDATE_CMD_LEN ||
						UPDATE_TEXT[8*(UPDATE_CMD_LEN-1-cmd_len) +: 8] != b))
					could_be_update = 1'b0;
				// a match wins over a buffer that fills on the same byte
				if (could_be_version && next_len == VERSION_CMD_LEN) begin
					record(ST_VERSION, 16'h0000, 8'h00);
					leave_command(MODE_COMMAND);
				end else if (could_be_update && next_len == UPDATE_CMD_LEN) begin
					record(ST_UPDATE, 16'h0000, 8'h00);
					leave_command(MODE_LENGTH);
				end else if (next_len >= CMD_BUF_BYTES) begin
					record(ST_CMD_ERROR, 16'h0000, 8'h00);
					leave_command(MODE_COMMAND);
				end else begin
					cmd_len = next_len;
				end
			end
			MODE_SKIP: begin
				if (b == LINE_FEED) begin
					cur_mode = resume_mode;
					resume_mode = MODE_COMMAND;
				end
			end
			MODE_LENGTH: begin
				if (b < MIN_FRAME_LENGTH || b > lim_max_len) begin
					record(ST_BAD_LENGTH, 16'h0000, 8'h00);
					cur_mode = MODE_SKIP;
					resume_mode = MODE_COMMAND;
				end else begin
					frame_len = b;
					sum_acc = b;
					frame_pos = 1;
					frame_addr = 16'h0000;
					cur_mode = MODE_BODY;
				end
			end
			default: begin
				sum_acc = sum_acc + b;
				if (frame_pos == 2)
					frame_addr[15:8] = b;
				else if (frame_pos == 3)
					frame_addr[7:0] = b;
				if (frame_pos + 1 < frame_len) begin
					frame_pos++;
				end else begin
					// frame complete: sum first, then address
					frame_pos = 0;
					cur_mode = MODE_SKIP;
					resume_mode = MODE_COMMAND;
					if (sum_acc != 8'h00)
						record(ST_BAD_SUM, 16'h0000, 8'h00);
					else if (frame_addr < lim_low || frame_addr > lim_high ||
							(frame_addr & lim_mask) != 16'h0000)
						record(ST_BAD_ADDRESS, frame_addr, 8'h00);
					else
						record(ST_OK, frame_addr, frame_len - MIN_FRAME_LENGTH);
				end
			end
		endcase
	endtask

	// popped result against the oldest predicted verdict
	task automatic compare_result();
		verdict_t want;
		if (pending_verdicts.size() == 0) begin
			if (fail_count < REPORT_LIMIT)
				$display("%0t: unexpected result status %0d address %h payload %0d",
					$time, status, frame_address, payload_bytes);
			fail_count++;
		end else begin
			want = pending_verdicts.pop_front();
			checked_count++;
			if (status !== want.status || frame_address !== want.addr ||
					payload_bytes !== want.payload) begin
				if (fail_count < REPORT_LIMIT)
					$display({"%0t: expected status %0d address %h payload %0d, ",
						"got status %0d address %h payload %0d"},
						$time, want.status, want.addr, want.payload,
						status, frame_address, payload_bytes);
				fail_count++;
			end
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_COMMAND;
			resume_mode = MODE_COMMAND;
			cmd_len = 0;
			could_be_version = 1'b1;
			could_be_update = 1'b1;
			sum_acc = 8'h00;
			frame_len = 8'h00;
			frame_pos = 0;
			frame_addr = 16'h0000;
			lim_low = RST_ADDRESS_LOWEST;
			lim_high = RST_ADDRESS_HIGHEST;
			lim_mask = RST_ALIGN_MASK;
			lim_max_len = RST_MAX_FRAME_LENGTH;
			pending_verdicts.delete();
			fail_count = 0;
			checked_count = 0;
			pending_count = 0;
		end else begin
			if (pop && !empty)
				compare_result();
			if (cfg_write) begin
				case (cfg_index)
					REG_ADDRESS_LOWEST:   lim_low = cfg_data;
					REG_ADDRESS_HIGHEST:  lim_high = cfg_data;
					REG_ALIGN_MASK:       lim_mask = cfg_data;
					REG_MAX_FRAME_LENGTH: lim_max_len = cfg_data[7:0];
					default: ;
				endcase
			end
			if (push && !full)
				parse_rx_byte(rx_byte);
			pending_count = pending_verdicts.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives AT command lines and update frames into the AT command and update
// frame checker under several limit settings, with bursty input and a
// stalling consumer, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module testbench;
	import afc_pkg::*;

	localparam int         CMD_BUF_BYTES = 12;
	localparam int         DRAIN_CYCLES  = 8;
	localparam int         RANDOM_BYTES  = 1400;
	localparam int         PHASES        = 10;
	localparam logic [7:0] FILLER        = 8'h78;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [15:0] frame_address;
	logic [7:0]  payload_bytes;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int          fail_count;
	int          pending_count;
	int          checked_count;

	int          bytes_sent;
	int          burst_left;
	int          gap_max;
	int          settings_used;
	bit          steady = 1'b0;
	logic [15:0] stall_pattern = 16'hFFFF;

	// limits currently programmed, used to steer stimulus
	logic [15:0] lim_low;
	logic [15:0] lim_high;
	logic [15:0] lim_mask;
	logic [7:0]  lim_max_len;

	string       version_text = "AT+V";
	string       update_text = "AT+UPDATE";

	at_command_and_update_frame_checker #(
		.COMMAND_BUFFER_BYTES(CMD_BUF_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.status(status),
		.frame_address(frame_address),
		.payload_bytes(payload_bytes),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	afc_result_checker #(
		.CMD_BUF_BYTES(CMD_BUF_BYTES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.status(status),
		.frame_address(frame_address),
		.payload_bytes(payload_bytes),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit: 5 ms
	initial begin
		#5000000;
		$display("testbench failed");
		$finish;
	end

	// consumer stalls on a rotating pattern
	initial begin : pop_driver
		int stall_phase;
		stall_phase = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= steady | stall_pattern[stall_phase];
			stall_phase = (stall_phase + 1) % 16;
		end
	end

	// one byte transaction, in bursts with random gaps
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every verdict has been popped
	task automatic settle();
		push <= 1'b0;
		burst_left = 0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_step(input reg_index_t idx, input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// program all four limit registers while idle
	task automatic apply_limits(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] mask, input logic [7:0] max_len);
		settle();
		write_step(REG_ADDRESS_LOWEST, lo);
		write_step(REG_ADDRESS_HIGHEST, hi);
		write_step(REG_ALIGN_MASK, mask);
		// upper byte of the length register is don't care
		write_step(REG_MAX_FRAME_LENGTH, {8'($urandom_range(0, 255)), max_len});
		cfg_write <= 1'b0;
		lim_low = lo;
		lim_high = hi;
		lim_mask = mask;
		lim_max_len = max_len;
		settings_used++;
	endtask

	function automatic logic [7:0] line_junk();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == LINE_FEED) ? 8'h0D : b;
	endfunction

	task automatic end_line();
		repeat ($urandom_range(0, 3)) send_byte(line_junk());
		send_byte(LINE_FEED);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// update command, then one frame with the address at offsets 2 and 3
	task automatic send_update_frame(input logic [7:0] len, input logic [15:0] addr,
			input bit good_sum);
		logic [7:0] sum;
		logic [7:0] b;
		send_text(update_text);
		end_line();
		send_byte(len);
		sum = len;
		if (len >= MIN_FRAME_LENGTH && len <= lim_max_len) begin
			for (int pos = 1; pos < len; pos++) begin
				if (pos == 2)
					b = addr[15:8];
				else if (pos == 3)
					b = addr[7:0];
				else if (pos == len - 1)
					b = good_sum ? -sum : -sum + 8'($urandom_range(1, 255));
				else
					b = 8'($urandom_range(0, 255));
				sum = sum + b;
				send_byte(b);
			end
		end
		end_line();
	endtask

	// command prefix broken by one byte, padded to a full buffer
	task automatic send_bad_command();
		int keep;
		logic [7:0] b;
		keep = $urandom_range(0, UPDATE_CMD_LEN - 1);
		for (int i = 0; i < CMD_BUF_BYTES; i++) begin
			if (i < keep) begin
				b = update_text[i];
			end else if (i == keep) begin
				b = 8'($urandom_range(0, 255));
				if (b == update_text[i] || (i < VERSION_CMD_LEN && b == version_text[i]))
					b = 8'h00;
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_byte(b);
		end
		end_line();
	endtask

	// raw bytes, then a line that brings the parser back to command mode
	task automatic send_noise();
		repeat ($urandom_range(1, 20))
			send_byte(($urandom_range(0, 3) == 0) ? LINE_FEED : 8'($urandom_range(0, 255)));
		repeat (CMD_BUF_BYTES) send_byte(FILLER);
		send_byte(LINE_FEED);
	endtask

	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		case ($urandom_range(0, 9))
			0, 1: a = 16'($urandom_range(0, 65535));
			2: a = ($urandom_range(0, 1) != 0) ? lim_low : lim_high;
			3: a = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
			default: begin
				if (lim_low <= lim_high)
					a = 16'($urandom_range(lim_low, lim_high)) & ~lim_mask;
				else
					a = 16'($urandom_range(0, 65535));
			end
		endcase
		return a;
	endfunction

	// mostly short legal frames, some at and past the limits
	function automatic logic [7:0] pick_length();
		int top_len;
		logic [7:0] len;
		top_len = (lim_max_len > 40) ? 40 : lim_max_len;
		case ($urandom_range(0, 19))
			0, 1: len = 8'($urandom_range(0, 255));
			2, 3: len = 8'($urandom_range(0, 4));
			4: len = lim_max_len;
			5: len = lim_max_len + 8'd1;
			default: begin
				if (top_len >= 5)
					len = 8'($urandom_range(5, top_len));
				else
					len = 8'($urandom_range(0, 255));
			end
		endcase
		return len;
	endfunction

	task automatic send_random_sequence();
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				send_text(version_text);
				end_line();
			end
			3, 4, 5: send_bad_command();
			6, 7: send_noise();
			default: send_update_frame(pick_length(), pick_address(), $urandom_range(0, 7) != 0);
		endcase
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int target;
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		cfg_write = 1'b0;
		cfg_index = REG_ADDRESS_LOWEST;
		cfg_data = 16'h0000;
		bytes_sent = 0;
		burst_left = 0;
		gap_max = 4;
		settings_used = 0;
		lim_low = RST_ADDRESS_LOWEST;
		lim_high = RST_ADDRESS_HIGHEST;
		lim_mask = RST_ALIGN_MASK;
		lim_max_len = RST_MAX_FRAME_LENGTH;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default limits
		send_text(version_text);
		end_line();
		send_update_frame(8'd5, 16'h8000, 1'b1);
		send_update_frame(RST_MAX_FRAME_LENGTH, 16'h9A00, 1'b1);
		send_update_frame(RST_MAX_FRAME_LENGTH + 8'd1, 16'h8000, 1'b1);
		send_update_frame(8'd4, 16'h8000, 1'b1);
		send_update_frame(8'd0, 16'h8000, 1'b1);
		// bad sum reported ahead of a bad address
		send_update_frame(8'd6, 16'h0001, 1'b0);
		send_update_frame(8'd5, 16'h9A10, 1'b1);
		send_update_frame(8'd5, 16'h7FF0, 1'b1);
		send_update_frame(8'd5, 16'h8001, 1'b1);
		// zero byte inside a command never matches
		send_text("AT");
		send_byte(8'h00);
		repeat (9) send_byte(8'hFF);
		end_line();
		// line end bytes count as command bytes
		send_byte(8'h0D);
		send_byte(LINE_FEED);
		send_text(version_text);
		repeat (6) send_byte(8'h00);
		end_line();

		// random sequences under several limit settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_limits(16'h0000, 16'hFFFF, 16'h0000, 8'd255);
				1: apply_limits(16'hFFFF, 16'h0000, 16'hFFFF, MIN_FRAME_LENGTH);
				2: apply_limits(16'h0000, 16'hFFFF, 16'h0001, 8'd0);
				3: apply_limits(RST_ADDRESS_LOWEST, RST_ADDRESS_HIGHEST, RST_ALIGN_MASK,
					RST_MAX_FRAME_LENGTH);
				default: begin : random_limits
					logic [15:0] lo;
					logic [15:0] mask;
					lo = 16'($urandom_range(0, 65535));
					case ($urandom_range(0, 4))
						0: mask = 16'h0000;
						1: mask = 16'h0001;
						2: mask = 16'h0003;
						3: mask = 16'h00FF;
						default: mask = 16'($urandom_range(0, 65535));
					endcase
					apply_limits(lo, lo + 16'($urandom_range(0, 16'h4000)), mask,
						($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(5, 48)));
				end
			endcase
			steady = (ph % 4 == 3);
			gap_max = $urandom_range(0, 8);
			stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
			target = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < target)
				send_random_sequence();
		end

		settle();
		$display("summary: %0d bytes sent, %0d results checked", bytes_sent, checked_count);
		$display("summary: %0d limit settings beyond reset, %0d failures", settings_used,
			fail_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/afc_pkg.sv
rtl/afc_front.sv
rtl/afc_queue.sv
rtl/afc_back.sv
rtl/at_command_and_update_frame_checker.sv
dv/afc_result_checker.sv
dv/testbench.sv
